/* hw/rtl/exponential_search_engine_top_macros.svh */
// assertion helpers shared by the search engine modules
`ifndef EXPONENTIAL_SEARCH_ENGINE_TOP_MACROS_SVH
`define EXPONENTIAL_SEARCH_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define ESE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ESE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ESE_ASSERT_NOW(lbl, ante, cons, msg)
`define ESE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/ese_pkg.sv */
package ese_pkg;

	localparam int unsigned IDX_BITS   = 10;
	localparam int unsigned FIELD_BITS = 32;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_FIRST,
		ST_EXP_LOOP,
		ST_EXP_CHK,
		ST_BIN_LOOP,
		ST_BIN_CHK,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		RD_LO,
		RD_PROBE,
		RD_MID
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_MISS,
		RES_LO,
		RES_MID
	} res_sel_t;

	typedef struct packed {
		logic     load_req;
		logic     wr_en;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     init_exp;
		logic     adv_exp;
		logic     set_bin;
		logic     bin_lo_up;
		logic     bin_hi_dn;
		res_sel_t res_sel;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic range_empty;
		logic probe_in;
		logic bin_open;
		logic key_eq;
		logic key_lt_entry;
		logic entry_lt_key;
	} dp_sts_t;

endpackage

/* hw/rtl/ese_datapath.sv */
`include "exponential_search_engine_top_macros.svh"

module ese_datapath
	import ese_pkg::*;
#(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_sts_t                      sts,
	input  logic        [IDX_BITS-1:0]   addr,
	input  logic signed [FIELD_BITS-1:0] value,
	input  logic signed [FIELD_BITS-1:0] key,
	input  logic        [IDX_BITS-1:0]   range_low,
	input  logic        [IDX_BITS-1:0]   range_high,
	output logic                         found,
	output logic        [IDX_BITS-1:0]   position
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned XW = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
	localparam logic [XW-1:0] TOP_X   = XW'(DEPTH - 1);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	logic [WORD_BITS-1:0] key_q;
	logic [XW-1:0]        lo_q, hi_q, step_q, probe_q, bl_q, bh_q, mid_q;
	logic                 res_found_q;
	logic [IDX_BITS-1:0]  res_pos_q;
	logic                 out_found_q;
	logic [IDX_BITS-1:0]  out_pos_q;

	logic [WORD_BITS-1:0] value_w, key_w, value_ord, key_ord;
	logic [XW-1:0]        wr_idx, high_x, hi_sat, mid_idx, rd_idx, bin_top;

	// sign-extend or truncate to the word width, then flip the sign bit so
	// unsigned compare gives signed order
	assign value_w   = WORD_BITS'(value);
	assign key_w     = WORD_BITS'(key);
	assign value_ord = {~value_w[WORD_BITS-1], value_w[WORD_BITS-2:0]};
	assign key_ord   = {~key_w[WORD_BITS-1], key_w[WORD_BITS-2:0]};

	assign wr_idx  = XW'(addr);
	assign high_x  = XW'(range_high);
	assign hi_sat  = (high_x >= DEPTH_X) ? TOP_X : high_x;
	assign mid_idx = bl_q + ((bh_q - bl_q - XW'(1)) >> 1);
	assign bin_top = (probe_q < hi_q) ? probe_q : hi_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_LO:    rd_idx = lo_q;
			RD_PROBE: rd_idx = probe_q;
			RD_MID:   rd_idx = mid_idx;
			default:  rd_idx = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (wr_idx < DEPTH_X)) begin
			mem[wr_idx[AW-1:0]] <= value_ord;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q <= key_ord;
			lo_q  <= XW'(range_low);
			hi_q  <= hi_sat;
		end
		if (cmd.init_exp) begin
			step_q  <= XW'(1);
			probe_q <= lo_q + XW'(1);
		end
		if (cmd.adv_exp) begin
			step_q  <= step_q << 1;
			probe_q <= lo_q + (step_q << 1);
		end
		if (cmd.set_bin) begin
			bl_q <= lo_q + (step_q >> 1);
			bh_q <= bin_top + XW'(1);
		end
		if (cmd.bin_lo_up) begin
			bl_q <= mid_q + XW'(1);
		end
		if (cmd.bin_hi_dn) begin
			bh_q <= mid_q;
		end
		if (cmd.rd_en && (cmd.rd_sel == RD_MID)) begin
			mid_q <= mid_idx;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_MISS: begin
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
			end
			RES_LO: begin
				res_found_q <= 1'b1;
				res_pos_q   <= lo_q[IDX_BITS-1:0];
			end
			RES_MID: begin
				res_found_q <= 1'b1;
				res_pos_q   <= mid_q[IDX_BITS-1:0];
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

	assign sts.range_empty  = lo_q > hi_q;
	assign sts.probe_in     = probe_q <= hi_q;
	assign sts.bin_open     = bl_q < bh_q;
	assign sts.key_eq       = rdata_q == key_q;
	assign sts.key_lt_entry = key_q < rdata_q;
	assign sts.entry_lt_key = rdata_q < key_q;

	assign found    = out_found_q;
	assign position = out_pos_q;

	`ESE_ASSERT_NOW(a_mid_in_window, cmd.rd_en && (cmd.rd_sel == RD_MID),
		(mid_idx >= bl_q) && (mid_idx < bh_q), "bisection probe outside its window")
	`ESE_ASSERT_NOW(a_probe_in_range, cmd.rd_en && (cmd.rd_sel == RD_PROBE),
		(probe_q <= hi_q) && (probe_q < DEPTH_X), "doubling probe beyond range end")
	`ESE_ASSERT_NEXT(a_bin_window_ok, cmd.set_bin, bl_q <= bh_q,
		"bisection window opened inverted")

endmodule

/* hw/rtl/ese_ctrl.sv */
`include "exponential_search_engine_top_macros.svh"

module ese_ctrl
	import ese_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    req_type,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					if (req_type == REQ_WRITE) begin
						cmd.wr_en   = 1'b1;
						cmd.res_sel = RES_MISS;
						state_d     = ST_DONE;
					end else begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (sts.range_empty) begin
					cmd.res_sel = RES_MISS;
					state_d     = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LO;
					state_d    = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (sts.key_eq) begin
					cmd.res_sel = RES_LO;
					state_d     = ST_DONE;
				end else begin
					cmd.init_exp = 1'b1;
					state_d      = ST_EXP_LOOP;
				end
			end
			ST_EXP_LOOP: begin
				if (sts.probe_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PROBE;
					state_d    = ST_EXP_CHK;
				end else begin
					cmd.set_bin = 1'b1;
					state_d     = ST_BIN_LOOP;
				end
			end
			ST_EXP_CHK: begin
				if (sts.entry_lt_key) begin
					cmd.adv_exp = 1'b1;
					state_d     = ST_EXP_LOOP;
				end else begin
					cmd.set_bin = 1'b1;
					state_d     = ST_BIN_LOOP;
				end
			end
			ST_BIN_LOOP: begin
				if (sts.bin_open) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
					state_d    = ST_BIN_CHK;
				end else begin
					cmd.res_sel = RES_MISS;
					state_d     = ST_DONE;
				end
			end
			ST_BIN_CHK: begin
				if (sts.key_eq) begin
					cmd.res_sel = RES_MID;
					state_d     = ST_DONE;
				end else if (sts.key_lt_entry) begin
					cmd.bin_hi_dn = 1'b1;
					state_d       = ST_BIN_LOOP;
				end else begin
					cmd.bin_lo_up = 1'b1;
					state_d       = ST_BIN_LOOP;
				end
			end
			ST_DONE: begin
				// result moves to the output slot once that slot is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`ESE_ASSERT_NOW(a_load_slot_free, cmd.load_out, !out_valid_q || out_ready,
		"result overwrote a beat not yet taken")
	`ESE_ASSERT_NEXT(a_write_to_done, in_valid && in_ready && (req_type == REQ_WRITE),
		state_q == ST_DONE, "write request did not go straight to result")
	`ESE_ASSERT_NOW(a_valid_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE,
		"result raised outside the done state")

endmodule

/* hw/rtl/exponential_search_engine_top.sv */
// exponential search engine
// input stream s_axis: one beat per request. tuser is the request kind
// (write or search); tdata carries addr, value, key, range_low, range_high.
// a write stores value at addr (ignored beyond the store); a search looks for
// key in the sorted entries range_low..range_high (high end clipped to the
// store) by doubling probes from range_low and then bisection.
// output stream m_axis: exactly one beat per request, tuser = found,
// tdata = zero-based position (0 when not found, and for writes).
// timing: one request at a time. a write passes from acceptance through the
// done state to the output register. a search checks its range, then each
// probe (first entry, doubling, bisection) uses the single store read port,
// which has a registered read, then the compare; the result then passes
// from the done state to the output register.
// the next request is taken as soon as the result sits in the output
// register, even while the receiver stalls; a stalled result only holds the
// engine once a second result is ready behind it.
// reset clears the controller and the output valid; store contents are
// undefined until written.
module exponential_search_engine_top
	import ese_pkg::*;
#(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// addr[9:0], value[41:10], key[73:42], range_low[83:74], range_high[93:84], zero pad
	input  logic [95:0] s_axis_tdata,
	// req_type[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// position[9:0], zero pad
	output logic [15:0] m_axis_tdata,
	// found[0]
	output logic        m_axis_tuser
);

	dp_cmd_t                      cmd;
	dp_sts_t                      sts;
	logic        [IDX_BITS-1:0]   addr, range_low, range_high, position;
	logic signed [FIELD_BITS-1:0] value, key;
	logic                         found;

	assign addr       = s_axis_tdata[9:0];
	assign value      = s_axis_tdata[41:10];
	assign key        = s_axis_tdata[73:42];
	assign range_low  = s_axis_tdata[83:74];
	assign range_high = s_axis_tdata[93:84];

	ese_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req_type  (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ese_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.addr       (addr),
		.value      (value),
		.key        (key),
		.range_low  (range_low),
		.range_high (range_high),
		.found      (found),
		.position   (position)
	);

	assign m_axis_tdata = {6'b0, position};
	assign m_axis_tuser = found;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
	import ese_pkg::*;

	localparam int STORE_DEPTH    = 1024;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int ITEM_TARGET    = 1550;
	localparam int HOLD_CYCLES    = 400;

	typedef logic signed [FIELD_BITS-1:0] word_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic  kind;
		idx_t  addr;
		word_t value;
		word_t key;
		idx_t  range_low;
		idx_t  range_high;
	} request_t;

	typedef struct {
		logic found;
		idx_t position;
	} answer_t;

	typedef enum {RCV_OPEN, RCV_COIN, RCV_SPARSE, RCV_PERIODIC} rcv_mode_t;

	class lookup_tracker;
		word_t   entries [STORE_DEPTH];
		answer_t outstanding [$];
		int      mismatches;
		int      writes;
		int      searches;
		int      hits;
		int      empties;

		// doubling probes from lo, then bisection over the last doubling interval
		function answer_t locate(word_t key, int lo, int hi);
			answer_t ans;
			int stride, probe, upper, l, h, mid;
			ans.found = 1'b0;
			ans.position = '0;
			if (hi > STORE_DEPTH - 1)
				hi = STORE_DEPTH - 1;
			if (lo > hi)
				return ans;
			if (entries[lo] == key) begin
				ans.found = 1'b1;
				ans.position = idx_t'(lo);
				return ans;
			end
			stride = 1;
			probe = lo + 1;
			while (probe <= hi && entries[probe] < key) begin
				stride = stride * 2;
				probe = lo + stride;
			end
			upper = (probe < hi) ? probe : hi;
			l = lo + stride / 2;
			h = upper;
			while (l <= h) begin
				mid = l + (h - l) / 2;
				if (key < entries[mid]) begin
					h = mid - 1;
				end else if (key > entries[mid]) begin
					l = mid + 1;
				end else begin
					ans.found = 1'b1;
					ans.position = idx_t'(mid);
					return ans;
				end
			end
			return ans;
		endfunction

		function void note_request(request_t req);
			answer_t ans;
			ans.found = 1'b0;
			ans.position = '0;
			if (req.kind == REQ_WRITE) begin
				entries[req.addr] = req.value;
				writes++;
			end else begin
				searches++;
				if (req.range_low > req.range_high)
					empties++;
				ans = locate(req.key, int'(req.range_low), int'(req.range_high));
				if (ans.found)
					hits++;
			end
			outstanding.push_back(ans);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_result(logic found, idx_t position);
			answer_t want;
			if (outstanding.size() == 0) begin
				flag($sformatf("result beat with nothing outstanding: found %b position %0d",
					found, position));
				return;
			end
			want = outstanding.pop_front();
			if (found !== want.found || position !== want.position)
				flag($sformatf("found %b position %0d, expected found %b position %0d",
					found, position, want.found, want.position));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	lookup_tracker tracker = new();

	int        beats_sent;
	int        burst_left;
	int        cycle_count;
	bit        hold_request;
	bit        second_hold;
	int        hold_left;
	int        mode_left;
	rcv_mode_t rcv_mode;

	exponential_search_engine_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.outstanding.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rcv_mode = rcv_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			case (rcv_mode)
				RCV_OPEN:   m_axis_tready <= 1'b1;
				RCV_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RCV_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:    m_axis_tready <= (mode_left % 3 != 0);
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			tracker.check_result(m_axis_tuser, m_axis_tdata[IDX_BITS-1:0]);

	task automatic send_request(request_t req);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk) s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req.kind;
		s_axis_tdata <= {2'b00, req.range_high, req.range_low, req.key, req.value, req.addr};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(req);
		beats_sent++;
	endtask

	// unused fields of each beat carry random junk the block must ignore
	task automatic write_entry(int addr, word_t value);
		request_t req;
		req.kind = REQ_WRITE;
		req.addr = idx_t'(addr);
		req.value = value;
		req.key = word_t'($urandom);
		req.range_low = idx_t'($urandom);
		req.range_high = idx_t'($urandom);
		send_request(req);
	endtask

	task automatic search_for(word_t key, int lo, int hi);
		request_t req;
		req.kind = REQ_SEARCH;
		req.addr = idx_t'($urandom);
		req.value = word_t'($urandom);
		req.key = key;
		req.range_low = idx_t'(lo);
		req.range_high = idx_t'(hi);
		send_request(req);
	endtask

	// search somewhere inside the written region rlo..rhi
	task automatic random_search(int rlo, int rhi);
		int lo, hi, pick, shape;
		word_t key;
		shape = $urandom_range(0, 9);
		if (shape == 0 || (shape == 1 && rhi == rlo)) begin
			lo = $urandom_range(rhi, rlo);
			hi = lo;
		end else if (shape == 1) begin
			lo = $urandom_range(rhi, rlo + 1);
			hi = $urandom_range(lo - 1, rlo);
		end else if (shape <= 4) begin
			lo = rlo;
			hi = rhi;
		end else begin
			lo = $urandom_range(rhi, rlo);
			hi = $urandom_range(rhi, lo);
		end
		pick = (lo <= hi) ? $urandom_range(hi, lo) : lo;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: key = tracker.entries[pick];
			4:          key = tracker.entries[pick] + 1;
			5:          key = tracker.entries[pick] - 1;
			6:          key = word_t'($urandom);
			7:          key = WORD_MIN;
			8:          key = WORD_MAX;
			default:    key = tracker.entries[lo] - 1;
		endcase
		search_for(key, lo, hi);
	endtask

	// ascending fill of the whole store, searching the filled part as it grows
	task automatic fill_store();
		longint level;
		level = longint'(WORD_MIN) + $urandom_range(0, 1000);
		for (int a = 0; a < STORE_DEPTH; a++) begin
			case ($urandom_range(0, 9))
				0, 1:       ;
				2, 3, 4, 5: level += $urandom_range(1, 3);
				default:    level += $urandom_range(1, 1 << 22);
			endcase
			if (level > 2147483647)
				level = 2147483647;
			write_entry(a, word_t'(level));
			if ($urandom_range(0, 2) == 0)
				random_search(0, a);
		end
	endtask

	// rewrite a short window, mostly keeping order with its neighbours
	task automatic rewrite_window();
		int n, base;
		longint lower, upper, level, spare;
		n = $urandom_range(1, 16);
		base = $urandom_range(STORE_DEPTH - n, 0);
		lower = (base > 0) ? tracker.entries[base - 1] : WORD_MIN;
		upper = (base + n < STORE_DEPTH) ? tracker.entries[base + n] : WORD_MAX;
		if (lower > upper) begin
			spare = lower;
			lower = upper;
			upper = spare;
		end
		level = lower;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				write_entry(base + i, word_t'($urandom));
			end else begin
				level += longint'({$urandom, $urandom} % ((upper - level) / (n - i) + 1));
				write_entry(base + i, word_t'(level));
			end
		end
		repeat ($urandom_range(2, 8))
			if ($urandom_range(0, 1))
				random_search(0, STORE_DEPTH - 1);
			else
				random_search(base, base + n - 1);
	endtask

	task automatic pause_until_drained();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (tracker.outstanding.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		write_entry(0, WORD_MIN);
		write_entry(1, -7);
		write_entry(2, -7);
		write_entry(3, 0);
		write_entry(4, 1);
		write_entry(5, 1000);
		write_entry(6, WORD_MAX - 1);
		write_entry(7, WORD_MAX);
		write_entry(STORE_DEPTH - 1, 12345);
		search_for(WORD_MIN, 0, 7);
		search_for(WORD_MAX, 0, 7);
		search_for(-7, 0, 7);
		search_for(1000, 0, 7);
		search_for(2, 0, 7);
		search_for(WORD_MIN + 1, 0, 7);
		search_for(0, 3, 3);
		search_for(1, 3, 3);
		search_for(0, 6, 2);
		search_for(12345, STORE_DEPTH - 1, STORE_DEPTH - 1);
		search_for(12344, STORE_DEPTH - 1, STORE_DEPTH - 1);
		search_for(WORD_MAX, 1, 6);
		search_for(WORD_MIN, 1, 7);
		search_for(1000, 2, 5);

		fill_store();
		pause_until_drained();
		hold_request = 1'b1;
		while (beats_sent < ITEM_TARGET) begin
			if (!second_hold && beats_sent > 1500) begin
				hold_request = 1'b1;
				second_hold = 1'b1;
			end
			rewrite_window();
		end

		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (tracker.outstanding.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("run: %0d write beats, %0d searches (%0d found, %0d empty ranges), %0d cycles",
			tracker.writes, tracker.searches, tracker.hits, tracker.empties, cycle_count);
		$display("with bursty input, output stall patterns, two long output holds, one drain");
		if (tracker.mismatches == 0 && tracker.outstanding.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ese_pkg.sv
hw/rtl/ese_datapath.sv
hw/rtl/ese_ctrl.sv
hw/rtl/exponential_search_engine_top.sv
sim/tb.sv
